### src/chol_pkg.sv
// Shared types and constants for the Cholesky solver.
package chol_pkg;

  typedef enum logic [1:0] {
    OP_MAT   = 2'd0,
    OP_RHS   = 2'd1,
    OP_SOLVE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_F_RD,
    ST_F_WAIT,
    ST_F_MAC,
    ST_F_DIAG_RD,
    ST_F_DIAG,
    ST_F_DIV,
    ST_F_WR,
    ST_S_RD,
    ST_S_WAIT,
    ST_S_MAC,
    ST_S_DIAG_RD,
    ST_S_DIV,
    ST_S_WR,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  localparam int unsigned CFG_SIZE = 0;

endpackage

### src/chol_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module chol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/cholesky_decompose_and_solve.sv
// Cholesky solver: a load item is taken while idle; a solve keeps busy high until its last result.
// A solve runs about n^3/6 + n^2 multiply-accumulate steps, n(n-1)/2 + 2n quotients and n square
// roots, then emits n results. The next item is taken after the last result.
// The factor memory has one read port and each factor MAC step reads it twice.
// Synchronous active-low reset returns control to idle and size_in_use to 16; memory contents
// are not cleared. Results cannot be stalled.
module cholesky_decompose_and_solve
  import chol_pkg::*;
#(
  parameter int MAX_N = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_row,
  input  logic [3:0]  in_col,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  output logic [3:0]  out_index,
  output logic signed [31:0] out_solution,
  output logic        out_not_positive_definite,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int AW  = 2 * IW;
  localparam int LIM = (MAX_N < 16) ? MAX_N : 16;
  localparam logic [4:0] LIM5 = 5'(LIM);

  // configuration
  logic [4:0] size_r;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'(4 * CFG_SIZE)) ? {27'd0, size_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 5'd16;
    end else if (psel && penable && pwrite && paddr == 2'(4 * CFG_SIZE)) begin
      size_r <= pwdata[4:0];
    end
  end

  // memories
  logic          m_we, f_we, b_we, y_we, x_we;
  logic [AW-1:0] m_wa, m_ra, f_wa, f_ra;
  logic [IW-1:0] b_wa, b_ra, y_wa, y_ra, x_wa, x_ra;
  logic [31:0]   m_wd, f_wd, b_wd, y_wd, x_wd, m_rd, f_rd, b_rd, y_rd, x_rd;

  chol_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_mat (.clk(clk), .we(m_we), .waddr(m_wa),
    .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
  chol_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_fac (.clk(clk), .we(f_we), .waddr(f_wa),
    .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
  chol_ram #(.WIDTH(32), .DEPTH(1 << IW)) u_rhs (.clk(clk), .we(b_we), .waddr(b_wa),
    .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
  // work vector holds y; x has a memory of its own
  chol_ram #(.WIDTH(32), .DEPTH(1 << IW)) u_wrk (.clk(clk), .we(y_we), .waddr(y_wa),
    .wdata(y_wd), .raddr(y_ra), .rdata(y_rd));
  chol_ram #(.WIDTH(32), .DEPTH(1 << IW)) u_x (.clk(clk), .we(x_we), .waddr(x_wa),
    .wdata(x_wd), .raddr(x_ra), .rdata(x_rd));

  function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    addr = {r, c};
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [65:0] v);
    if (v > 66'sd2147483647) sat = 32'sh7fffffff;
    else if (v < -66'sd2147483648) sat = 32'sh80000000;
    else sat = v[31:0];
  endfunction

  function automatic logic [31:0] mag(input logic signed [31:0] v);
    mag = v[31] ? 32'(-v) : 32'(v);
  endfunction

  // control
  state_t state_r, state_nxt;
  logic [IW-1:0] n1_r;          // n-1
  logic [IW-1:0] i_r, j_r, k_r;
  logic [IW-1:0] i_nxt, j_nxt, k_nxt;
  logic          phase_r, phase_nxt;   // 0 forward, 1 backward
  logic          bad_r, bad_nxt;
  logic signed [55:0] acc_r, acc_nxt;
  logic signed [31:0] d_r, d_nxt;
  logic signed [31:0] op_a_r, op_b_r, op_a_nxt, op_b_nxt;
  logic signed [63:0] prod_r;
  logic          mac_en_nxt, mac_p1_r, mac_en_r;

  // iterative unit: sqrt of d*2^16 or quotient (num*2^16)/den, one result bit a cycle
  logic          it_start, it_sqrt, it_busy_r, it_done_r, it_sqrt_r;
  logic [5:0]    it_cnt_r;
  logic [63:0]   it_rem_r, it_q_r, it_den_r, it_num_r;
  logic          it_neg_r;
  logic signed [31:0] it_res;

  logic [4:0] n_eff;
  assign n_eff = (size_r == 5'd0) ? 5'd1 : ((size_r > LIM5) ? LIM5 : size_r);

  // product pipeline: operands, registered product, then round and accumulate
  logic signed [63:0] prod_rnd;
  logic signed [47:0] qm;
  always_ff @(posedge clk) begin
    prod_r <= op_a_r * op_b_r;
    if (!rst_n) begin
      mac_p1_r <= 1'b0;
      mac_en_r <= 1'b0;
    end else begin
      mac_p1_r <= mac_en_nxt;
      mac_en_r <= mac_p1_r;
    end
  end
  assign prod_rnd = prod_r + 64'sd32768;
  assign qm = prod_rnd[63:16];

  // loads
  wire acc_in = start && !busy;
  wire [3:0] lim_m1 = 4'(LIM - 1);

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r;
    phase_nxt = phase_r; bad_nxt = bad_r;
    acc_nxt = acc_r; d_nxt = d_r;
    op_a_nxt = op_a_r; op_b_nxt = op_b_r; mac_en_nxt = 1'b0;
    m_we = 1'b0; m_wa = addr(IW'(in_row), IW'(in_col)); m_wd = in_value; m_ra = addr(i_r, j_r);
    f_we = 1'b0; f_wa = addr(i_r, j_r); f_wd = it_res; f_ra = addr(i_r, k_r);
    b_we = 1'b0; b_wa = IW'(in_row); b_wd = in_value; b_ra = i_r;
    y_we = 1'b0; y_wa = i_r; y_wd = it_res; y_ra = k_r;
    x_we = 1'b0; x_wa = i_r; x_wd = it_res; x_ra = k_r;
    it_start = 1'b0; it_sqrt = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          case (op_t'(in_op))
            OP_MAT: m_we = (in_row <= lim_m1) && (in_col <= in_row);
            OP_RHS: b_we = (in_row <= lim_m1);
            OP_SOLVE: begin
              i_nxt = '0; j_nxt = '0; k_nxt = '0; bad_nxt = 1'b0;
              acc_nxt = '0; phase_nxt = 1'b0;
              state_nxt = ST_F_RD;
            end
            default: ;
          endcase
        end
      end
      // factor: acc = sum_k L[i,k]*L[j,k] for k<j
      ST_F_RD: begin
        acc_nxt = '0; k_nxt = '0;
        state_nxt = (j_r == '0) ? ST_F_DIAG_RD : ST_F_WAIT;
        f_ra = addr(i_r, '0);
      end
      ST_F_WAIT: begin
        // read L[j,k] while L[i,k] is on the port
        op_a_nxt = f_rd;
        f_ra = addr(j_r, k_r);
        state_nxt = ST_F_MAC;
      end
      ST_F_MAC: begin
        op_b_nxt = f_rd; mac_en_nxt = 1'b1;
        if (k_r + 1'b1 == j_r) begin
          state_nxt = ST_F_DIAG_RD;
        end else begin
          k_nxt = k_r + 1'b1;
          f_ra = addr(i_r, k_r + 1'b1);
          state_nxt = ST_F_WAIT;
        end
      end
      ST_F_DIAG_RD: begin
        // drain the product pipeline, fetch M[i,j] and L[j,j]
        m_ra = addr(i_r, j_r);
        f_ra = addr(j_r, j_r);
        if (!mac_p1_r && !mac_en_r) state_nxt = ST_F_DIAG;
      end
      ST_F_DIAG: begin
        f_ra = addr(j_r, j_r);
        d_nxt = sat({{34{m_rd[31]}}, m_rd} - {{10{acc_r[55]}}, acc_r});
        state_nxt = ST_F_DIV;
      end
      ST_F_DIV: begin
        if (!it_busy_r && !it_done_r) begin
          if (i_r == j_r && d_r <= 0) begin
            bad_nxt = 1'b1; i_nxt = '0; state_nxt = ST_EMIT_RD;
          end else begin
            it_start = 1'b1; it_sqrt = (i_r == j_r);
          end
        end
        if (it_done_r) state_nxt = ST_F_WR;
      end
      ST_F_WR: begin
        f_we = 1'b1;
        if (j_r == i_r) begin
          j_nxt = '0;
          if (i_r == n1_r) begin
            i_nxt = '0; phase_nxt = 1'b0; state_nxt = ST_S_RD;
          end else begin
            i_nxt = i_r + 1'b1; state_nxt = ST_F_RD;
          end
        end else begin
          j_nxt = j_r + 1'b1; state_nxt = ST_F_RD;
        end
      end
      // substitution: forward uses L[i,k]*y[k], backward L[k,i]*x[k]
      ST_S_RD: begin
        acc_nxt = '0;
        k_nxt = phase_r ? i_r + 1'b1 : '0;
        if ((!phase_r && i_r == '0) || (phase_r && i_r == n1_r)) begin
          state_nxt = ST_S_DIAG_RD;
        end else begin
          state_nxt = ST_S_WAIT;
        end
      end
      ST_S_WAIT: begin
        f_ra = phase_r ? addr(k_r, i_r) : addr(i_r, k_r);
        y_ra = k_r; x_ra = k_r;
        state_nxt = ST_S_MAC;
      end
      ST_S_MAC: begin
        op_a_nxt = f_rd; op_b_nxt = phase_r ? x_rd : y_rd; mac_en_nxt = 1'b1;
        if ((!phase_r && k_r + 1'b1 == i_r) || (phase_r && k_r == n1_r)) begin
          state_nxt = ST_S_DIAG_RD;
        end else begin
          k_nxt = k_r + 1'b1; state_nxt = ST_S_WAIT;
        end
      end
      ST_S_DIAG_RD: begin
        f_ra = addr(i_r, i_r); b_ra = i_r; y_ra = i_r;
        if (!mac_p1_r && !mac_en_r) state_nxt = ST_S_DIV;
      end
      ST_S_DIV: begin
        if (!it_busy_r && !it_done_r) begin
          d_nxt = sat({{34{(phase_r ? y_rd[31] : b_rd[31])}}, (phase_r ? y_rd : b_rd)}
                      - {{10{acc_r[55]}}, acc_r});
          it_start = 1'b1;
        end
        if (it_done_r) state_nxt = ST_S_WR;
      end
      ST_S_WR: begin
        y_we = !phase_r; x_we = phase_r;
        if (!phase_r) begin
          if (i_r == n1_r) begin
            phase_nxt = 1'b1; state_nxt = ST_S_RD;
          end else begin
            i_nxt = i_r + 1'b1; state_nxt = ST_S_RD;
          end
        end else if (i_r == '0) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          i_nxt = i_r - 1'b1; state_nxt = ST_S_RD;
        end
      end
      ST_EMIT_RD: begin
        x_ra = i_r;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        x_ra = i_r + 1'b1;
        if (i_r == n1_r) state_nxt = ST_IDLE;
        else i_nxt = i_r + 1'b1;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (mac_en_r) acc_nxt = acc_r + 56'(qm);
  end

  assign busy = (state_r != ST_IDLE);
  assign out_index = 4'(i_r);
  assign out_solution = bad_r ? 32'sd0 : x_rd;
  assign out_not_positive_definite = bad_r;
  assign out_last = (i_r == n1_r);

  // iterative divider / square root
  logic [63:0] it_trial;
  logic [63:0] it_sub;
  logic signed [63:0] it_qs;
  always_comb begin
    it_trial = it_sqrt_r ? ((it_q_r << 2) | 64'd1) : it_den_r;
    it_sub   = {it_rem_r[61:0], it_num_r[63:62]};
    if (!it_sqrt_r) it_sub = {it_rem_r[62:0], it_num_r[63]};
    it_qs = it_neg_r ? -$signed(it_q_r) : $signed(it_q_r);
    it_res = it_sqrt_r ? it_q_r[31:0] : sat(66'(it_qs));
  end

  // The radicand d*2^16 and the dividend |d|*2^16 both sit in the top 48 bits of it_num_r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_busy_r <= 1'b0; it_done_r <= 1'b0;
    end else if (it_start) begin
      it_busy_r <= 1'b1; it_done_r <= 1'b0;
      it_sqrt_r <= it_sqrt;
      it_rem_r  <= '0; it_q_r <= '0;
      it_cnt_r  <= it_sqrt ? 6'd23 : 6'd47;
      if (it_sqrt) begin
        it_num_r <= {d_r, 32'd0};
        it_neg_r <= 1'b0;
      end else begin
        it_neg_r <= (state_r == ST_F_DIV) ? d_r[31] : d_nxt[31];
        it_num_r <= {((state_r == ST_F_DIV) ? mag(d_r) : mag(d_nxt)), 32'd0};
        it_den_r <= {32'd0, f_rd};
      end
    end else if (it_busy_r) begin
      if (it_sqrt_r) begin
        it_num_r <= it_num_r << 2;
        if (it_sub >= it_trial) begin
          it_rem_r <= it_sub - it_trial; it_q_r <= (it_q_r << 1) | 64'd1;
        end else begin
          it_rem_r <= it_sub; it_q_r <= it_q_r << 1;
        end
      end else begin
        it_num_r <= it_num_r << 1;
        if (it_sub >= it_trial) begin
          it_rem_r <= it_sub - it_trial; it_q_r <= (it_q_r << 1) | 64'd1;
        end else begin
          it_rem_r <= it_sub; it_q_r <= it_q_r << 1;
        end
      end
      if (it_cnt_r == '0) begin
        it_busy_r <= 1'b0; it_done_r <= 1'b1;
      end
      it_cnt_r <= it_cnt_r - 1'b1;
    end else begin
      it_done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r <= '0; j_r <= '0; k_r <= '0;
      phase_r <= 1'b0; bad_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt;
      phase_r <= phase_nxt; bad_r <= bad_nxt;
    end
    if (state_r == ST_IDLE) n1_r <= IW'(n_eff - 5'd1);
    acc_r <= acc_nxt; d_r <= d_nxt;
    op_a_r <= op_a_nxt; op_b_r <= op_b_nxt;
  end

endmodule
